// ----- design/hwu_pkg.sv -----
// Shared constants, types and the arctangent table for the heading unit.
`default_nettype none

package hwu_pkg;

	// Default configuration of the unit
	localparam int HWU_COORD_WIDTH     = 16;
	localparam int HWU_ANGLE_FRAC_BITS = 13;
	localparam int HWU_CORDIC_STAGES   = 14;

	// CORDIC datapath widths: x/y are 64-bit two's complement, z is signed Q.30
	localparam int XY_W  = 64;
	localparam int Z_W   = 33;
	localparam int ANG_W = 34;
	localparam int XY_TOP = 60;

	// Angle constants, unsigned radians in Q.30
	localparam logic [ANG_W-1:0] Q30_PI      = 34'd3373259426;
	localparam logic [ANG_W-1:0] Q30_HALF_PI = 34'd1686629713;
	localparam logic [ANG_W-1:0] Q30_TWO_PI  = 34'd6746518853;

	// Vector state handed from cell to cell
	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} cordic_vec_t;

	// atan(2^-i) in Q.30, rounded down; zero past the end of the table
	function automatic logic [29:0] atan_q30(input int unsigned i);
		logic [29:0] v;
		case (i)
			0:  v = 30'd843314856;
			1:  v = 30'd497837829;
			2:  v = 30'd263043836;
			3:  v = 30'd133525158;
			4:  v = 30'd67021686;
			5:  v = 30'd33543515;
			6:  v = 30'd16775850;
			7:  v = 30'd8388437;
			8:  v = 30'd4194282;
			9:  v = 30'd2097149;
			10: v = 30'd1048575;
			11: v = 30'd524287;
			12: v = 30'd262143;
			13: v = 30'd131071;
			14: v = 30'd65535;
			15: v = 30'd32767;
			16: v = 30'd16383;
			17: v = 30'd8191;
			18: v = 30'd4095;
			19: v = 30'd2047;
			20: v = 30'd1023;
			21: v = 30'd511;
			22: v = 30'd255;
			23: v = 30'd127;
			24: v = 30'd63;
			25: v = 30'd31;
			26: v = 30'd15;
			27: v = 30'd7;
			28: v = 30'd3;
			29: v = 30'd1;
			default: v = 30'd0;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

// ----- design/heading_to_waypoint_unit.sv -----
// Top level: heading from a current position to a target, CORDIC cell chain.
//
//  channel   dir  beats/request  content (lowest bits first)
//  s_axis    in   1              current_x, current_y, target_x, target_y
//  m_axis    out  2              pose_x, pose_y, heading; tlast on second beat
//
// The output port sends two beats (current pose, then target pose) per request
// and takes the next pair while the second beat of the last one leaves.
// Reset clears only the valid bits of the input register and the cells and the
// full and phase bits of the output stage; payload registers are not reset.
// A pair waiting in the last cell while the output stage cannot take it
// freezes every cell and drops s_axis_tready, even with bubbles further up.
`default_nettype none

module heading_to_waypoint_unit #(
	parameter int COORD_WIDTH     = hwu_pkg::HWU_COORD_WIDTH,
	parameter int ANGLE_FRAC_BITS = hwu_pkg::HWU_ANGLE_FRAC_BITS,
	parameter int CORDIC_STAGES   = hwu_pkg::HWU_CORDIC_STAGES
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	// current_x, current_y, target_x, target_y
	input  wire                                    s_axis_tvalid,
	output logic                                   s_axis_tready,
	input  wire  [((4*COORD_WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	// pose_x, pose_y, heading
	output logic                                   m_axis_tvalid,
	input  wire                                    m_axis_tready,
	output logic [((2*COORD_WIDTH+16+7)/8)*8-1:0]  m_axis_tdata,
	output logic                                   m_axis_tlast
);

	localparam int CW     = COORD_WIDTH;
	localparam int META_W = 4*CW + 3;
	localparam int SH     = hwu_pkg::XY_TOP - CW;
	localparam int RND    = 30 - ANGLE_FRAC_BITS;
	localparam int AW     = hwu_pkg::ANG_W;

	localparam logic [AW-1:0] HALF_LSB   = AW'(1) << (RND - 1);
	localparam logic [AW-1:0] PI_RND     = hwu_pkg::Q30_PI + HALF_LSB;
	localparam logic [AW-1:0] TWO_PI_RND = hwu_pkg::Q30_TWO_PI + HALF_LSB;
	localparam logic [AW-1:0] WRAP_LIM   = TWO_PI_RND >> RND;

	// Quadrant of the difference vector: {dx negative, dy negative}
	localparam logic [1:0] QUAD_FIRST  = 2'b00;
	localparam logic [1:0] QUAD_SECOND = 2'b10;
	localparam logic [1:0] QUAD_THIRD  = 2'b11;
	localparam logic [1:0] QUAD_FOURTH = 2'b01;

	logic                 en;
	logic                 vld_s1;
	logic signed [CW-1:0] cx_s1;
	logic signed [CW-1:0] cy_s1;
	logic signed [CW-1:0] tx_s1;
	logic signed [CW-1:0] ty_s1;

	logic signed [CW:0]   dx;
	logic signed [CW:0]   dy;
	logic [CW:0]          adx;
	logic [CW:0]          ady;
	logic                 dzero;

	logic                 vld   [0:CORDIC_STAGES];
	hwu_pkg::cordic_vec_t vec   [0:CORDIC_STAGES];
	logic [META_W-1:0]    meta  [0:CORDIC_STAGES];

	logic [META_W-1:0]    meta_end;
	logic signed [hwu_pkg::Z_W-1:0] z_end;
	logic [AW-1:0]        t_ang;
	logic [AW-1:0]        a_rnd;
	logic [AW-1:0]        h_full;
	logic [15:0]          heading;
	logic                 load_rdy;

	// Advance the whole chain unless its last cell holds a pair the output can't take
	assign en            = !vld[CORDIC_STAGES] || load_rdy;
	assign s_axis_tready = en;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && s_axis_tvalid) begin
			cx_s1 <= s_axis_tdata[CW-1:0];
			cy_s1 <= s_axis_tdata[2*CW-1:CW];
			tx_s1 <= s_axis_tdata[3*CW-1:2*CW];
			ty_s1 <= s_axis_tdata[4*CW-1:3*CW];
		end
	end

	// Exact difference, one bit wider than the coordinates, and its magnitude
	assign dx    = {tx_s1[CW-1], tx_s1} - {cx_s1[CW-1], cx_s1};
	assign dy    = {ty_s1[CW-1], ty_s1} - {cy_s1[CW-1], cy_s1};
	assign adx   = dx[CW] ? (CW+1)'(-dx) : dx;
	assign ady   = dy[CW] ? (CW+1)'(-dy) : dy;
	assign dzero = (dx == '0) && (dy == '0);

	// Feed the first cell with the magnitudes scaled to the top of the datapath
	assign vld[0]   = vld_s1;
	assign vec[0].x = hwu_pkg::XY_W'(adx) << SH;
	assign vec[0].y = hwu_pkg::XY_W'(ady) << SH;
	assign vec[0].z = '0;
	assign meta[0]  = {dzero, dx[CW], dy[CW], ty_s1, tx_s1, cy_s1, cx_s1};

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		hwu_cell #(
			.STAGE  (g),
			.META_W (META_W)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_vld   (vld[g]),
			.in_vec   (vec[g]),
			.in_meta  (meta[g]),
			.out_vld  (vld[g+1]),
			.out_vec  (vec[g+1]),
			.out_meta (meta[g+1])
		);
	end

	assign meta_end = meta[CORDIC_STAGES];
	assign z_end    = vec[CORDIC_STAGES].z;

	// Clamp the first-quadrant angle to [0, pi/2]
	always_comb begin
		if (z_end[hwu_pkg::Z_W-1]) begin
			t_ang = '0;
		end else if (AW'(z_end[hwu_pkg::Z_W-2:0]) > hwu_pkg::Q30_HALF_PI) begin
			t_ang = hwu_pkg::Q30_HALF_PI;
		end else begin
			t_ang = AW'(z_end[hwu_pkg::Z_W-2:0]);
		end
	end

	// Quadrant correction with the rounding half folded into the constants
	always_comb begin
		case (meta_end[META_W-2 -: 2])
			QUAD_FIRST:  a_rnd = t_ang + HALF_LSB;
			QUAD_SECOND: a_rnd = PI_RND - t_ang;
			QUAD_THIRD:  a_rnd = PI_RND + t_ang;
			QUAD_FOURTH: a_rnd = TWO_PI_RND - t_ang;
			default:     a_rnd = '0;
		endcase
	end

	assign h_full = a_rnd >> RND;

	// Drop to zero for a zero difference or a value that rounds to 2pi
	always_comb begin
		if (meta_end[META_W-1] || (h_full >= WRAP_LIM)) begin
			heading = '0;
		end else begin
			heading = h_full[15:0];
		end
	end

	hwu_emit #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_emit (
		.clk           (clk),
		.arst_n        (arst_n),
		.load_vld      (vld[CORDIC_STAGES]),
		.load_rdy      (load_rdy),
		.cur_x         (meta_end[CW-1:0]),
		.cur_y         (meta_end[2*CW-1:CW]),
		.tgt_x         (meta_end[3*CW-1:2*CW]),
		.tgt_y         (meta_end[4*CW-1:3*CW]),
		.heading       (heading),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

`default_nettype wire

// ----- design/hwu_cell.sv -----
// One CORDIC vectoring cell: a single micro-rotation and its register.
`default_nettype none

module hwu_cell #(
	parameter int STAGE  = 0,
	parameter int META_W = 67
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   en,
	input  wire                   in_vld,
	input  wire hwu_pkg::cordic_vec_t in_vec,
	input  wire  [META_W-1:0]     in_meta,
	output logic                  out_vld,
	output hwu_pkg::cordic_vec_t  out_vec,
	output logic [META_W-1:0]     out_meta
);

	localparam logic [hwu_pkg::Z_W-1:0] ATAN_STEP =
		hwu_pkg::Z_W'(hwu_pkg::atan_q30(STAGE));

	logic signed [hwu_pkg::XY_W-1:0] xs;
	logic signed [hwu_pkg::XY_W-1:0] ys;
	hwu_pkg::cordic_vec_t            nxt;

	assign xs = $signed(in_vec.x) >>> STAGE;
	assign ys = $signed(in_vec.y) >>> STAGE;

	// Rotate toward the x axis: the sign of y picks the direction
	always_comb begin
		if (!in_vec.y[hwu_pkg::XY_W-1]) begin
			nxt.x = in_vec.x + ys;
			nxt.y = in_vec.y - xs;
			nxt.z = in_vec.z + ATAN_STEP;
		end else begin
			nxt.x = in_vec.x - ys;
			nxt.y = in_vec.y + xs;
			nxt.z = in_vec.z - ATAN_STEP;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_vec  <= nxt;
			out_meta <= in_meta;
		end
	end

endmodule

`default_nettype wire

// ----- design/hwu_emit.sv -----
// Output stage: holds one finished pair and sends it as two stream beats.
`default_nettype none

module hwu_emit #(
	parameter int COORD_WIDTH = hwu_pkg::HWU_COORD_WIDTH
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       load_vld,
	output logic                      load_rdy,
	input  wire  [COORD_WIDTH-1:0]    cur_x,
	input  wire  [COORD_WIDTH-1:0]    cur_y,
	input  wire  [COORD_WIDTH-1:0]    tgt_x,
	input  wire  [COORD_WIDTH-1:0]    tgt_y,
	input  wire  [15:0]               heading,
	output logic                      m_axis_tvalid,
	input  wire                       m_axis_tready,
	output logic [((2*COORD_WIDTH+16+7)/8)*8-1:0] m_axis_tdata,
	output logic                      m_axis_tlast
);

	localparam int OUT_DATA_W = ((2*COORD_WIDTH+16+7)/8)*8;

	logic                   full_q;
	logic                   phase_q;
	logic                   load;
	logic                   beat_done;
	logic [COORD_WIDTH-1:0] cur_x_q;
	logic [COORD_WIDTH-1:0] cur_y_q;
	logic [COORD_WIDTH-1:0] tgt_x_q;
	logic [COORD_WIDTH-1:0] tgt_y_q;
	logic [15:0]            heading_q;
	logic [COORD_WIDTH-1:0] pose_x;
	logic [COORD_WIDTH-1:0] pose_y;

	// Take a new pair when empty or while the second beat leaves
	assign load_rdy  = !full_q || (phase_q && m_axis_tready);
	assign load      = load_vld && load_rdy;
	assign beat_done = full_q && m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q  <= 1'b0;
			phase_q <= 1'b0;
		end else if (load) begin
			full_q  <= 1'b1;
			phase_q <= 1'b0;
		end else if (beat_done) begin
			if (phase_q) begin
				full_q  <= 1'b0;
				phase_q <= 1'b0;
			end else begin
				phase_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cur_x_q   <= cur_x;
			cur_y_q   <= cur_y;
			tgt_x_q   <= tgt_x;
			tgt_y_q   <= tgt_y;
			heading_q <= heading;
		end
	end

	assign pose_x = phase_q ? tgt_x_q : cur_x_q;
	assign pose_y = phase_q ? tgt_y_q : cur_y_q;

	assign m_axis_tvalid = full_q;
	assign m_axis_tlast  = phase_q;
	assign m_axis_tdata  = OUT_DATA_W'({heading_q, pose_y, pose_x});

endmodule

`default_nettype wire

// ----- design/hwu_check.sv -----
// Port-level checks of the heading unit, bound to the top level.
`default_nettype none

module hwu_check #(
	parameter int COORD_WIDTH = hwu_pkg::HWU_COORD_WIDTH
) (
	input wire                                    clk,
	input wire                                    arst_n,
	input wire                                    s_axis_tvalid,
	input wire                                    s_axis_tready,
	input wire [((4*COORD_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
	input wire                                    m_axis_tvalid,
	input wire                                    m_axis_tready,
	input wire [((2*COORD_WIDTH+16+7)/8)*8-1:0]   m_axis_tdata,
	input wire                                    m_axis_tlast
);

	localparam int HB = 2*COORD_WIDTH;

	// Hold a waiting input request until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && !s_axis_tready |=>
			s_axis_tvalid && $stable(s_axis_tdata))
		else $error("waiting input request changed");

	// Hold a stalled beat
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("stalled output beat changed");

	// The target pose follows the current pose at once
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tvalid && m_axis_tlast)
		else $error("second pose of a pair missing");

	// Both poses of a pair carry the same heading
	assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tdata[HB+15:HB] == $past(m_axis_tdata[HB+15:HB]))
		else $error("heading differs within a pair");

	// A new run of output always starts with the current pose
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> !m_axis_tlast)
		else $error("pair started with the target pose");

endmodule

bind heading_to_waypoint_unit hwu_check #(
	.COORD_WIDTH (COORD_WIDTH)
) u_hwu_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ----- dv/heading_to_waypoint_unit_test.sv -----
// Self-checking testbench for the waypoint heading unit: random and directed requests.
`default_nettype none

module heading_to_waypoint_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COORD_W      = hwu_pkg::HWU_COORD_WIDTH;
	localparam int ANGLE_FRAC   = hwu_pkg::HWU_ANGLE_FRAC_BITS;
	localparam int STAGES       = hwu_pkg::HWU_CORDIC_STAGES;
	localparam int HEADING_W    = 16;
	localparam int S_DATA_W     = ((4*COORD_W+7)/8)*8;
	localparam int M_DATA_W     = ((2*COORD_W+16+7)/8)*8;
	localparam int RESET_CYCLES = 12;
	// Drain time: allows for the cell chain, the second pose and some slack.
	localparam int DRAIN_CYCLES = STAGES + 12;
	// Longest honest quiet stretch is the hold-off below plus the chain latency.
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int RANDOM_REQUESTS = 440;
	localparam int HOLD_REQUESTS   = 60;
	localparam int REPORT_LIMIT    = 10;

	// Angle constants in Q.30
	localparam longint PI_Q30      = longint'(hwu_pkg::Q30_PI);
	localparam longint HALF_PI_Q30 = longint'(hwu_pkg::Q30_HALF_PI);
	localparam longint TWO_PI_Q30  = longint'(hwu_pkg::Q30_TWO_PI);
	localparam int     ROUND_SHIFT = 30 - ANGLE_FRAC;

	// atan(2^-i) in Q.30, rounded down
	localparam longint ARCTAN_STEP [0:15] = '{
		843314856, 497837829, 263043836, 133525158,
		67021686, 33543515, 16775850, 8388437,
		4194282, 2097149, 1048575, 524287,
		262143, 131071, 65535, 32767
	};

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		coord_t                x;
		coord_t                y;
		logic [HEADING_W-1:0]  heading;
		logic                  last;
	} pose_t;

	// Receiver stall patterns
	typedef enum logic [1:0] {
		RX_STREAM,
		RX_COIN,
		RX_CHOKE
	} rx_mode_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_axis_tvalid = 1'b0;
	logic                s_axis_tready;
	logic [S_DATA_W-1:0] s_axis_tdata = '0;
	logic                m_axis_tvalid;
	logic                m_axis_tready = 1'b0;
	logic [M_DATA_W-1:0] m_axis_tdata;
	logic                m_axis_tlast;

	pose_t expected_poses[$];
	int    fault_count      = 0;
	int    requests_sent    = 0;
	int    poses_checked    = 0;
	int    zero_offsets     = 0;
	int    input_held_cycles = 0;
	int    burst_left       = 0;
	bit    hold_off_req     = 1'b0;

	heading_to_waypoint_unit #(
		.COORD_WIDTH     (COORD_W),
		.ANGLE_FRAC_BITS (ANGLE_FRAC),
		.CORDIC_STAGES   (STAGES)
	) u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Heading of (target - current) in the output angle format.
	function automatic logic [HEADING_W-1:0] predict_heading(coord_t cx, coord_t cy,
			coord_t tx, coord_t ty);
		longint            dx;
		longint            dy;
		longint            mag_x;
		longint            mag_y;
		logic signed [63:0] vx;
		logic signed [63:0] vy;
		logic signed [63:0] shx;
		logic signed [63:0] shy;
		longint            z;
		longint            quad_angle;
		longint            full_angle;
		longint            rounded;
		longint            wrap_at;
		dx = tx - cy * 0 - cx;
		dy = ty - cy;
		if (dx == 0 && dy == 0) begin
			return '0;
		end
		mag_x = (dx < 0) ? -dx : dx;
		mag_y = (dy < 0) ? -dy : dy;
		// Scale magnitudes up to the top of the 64-bit datapath
		vx = mag_x <<< (60 - COORD_W);
		vy = mag_y <<< (60 - COORD_W);
		z  = 0;
		for (int i = 0; i < STAGES; i++) begin
			shx = vx >>> i;
			shy = vy >>> i;
			if (vy >= 0) begin
				vx = vx + shy;
				vy = vy - shx;
				z  = z + ARCTAN_STEP[i];
			end else begin
				vx = vx - shy;
				vy = vy + shx;
				z  = z - ARCTAN_STEP[i];
			end
		end
		// Clamp to the first quadrant
		if (z < 0) begin
			quad_angle = 0;
		end else if (z > HALF_PI_Q30) begin
			quad_angle = HALF_PI_Q30;
		end else begin
			quad_angle = z;
		end
		if (dx >= 0 && dy >= 0) begin
			full_angle = quad_angle;
		end else if (dx < 0 && dy >= 0) begin
			full_angle = PI_Q30 - quad_angle;
		end else if (dx < 0) begin
			full_angle = PI_Q30 + quad_angle;
		end else begin
			full_angle = TWO_PI_Q30 - quad_angle;
		end
		// Round half up; a result that lands on 2pi wraps to zero
		rounded = (full_angle + (longint'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
		wrap_at = (TWO_PI_Q30 + (longint'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
		if (rounded >= wrap_at) begin
			rounded = 0;
		end
		return rounded[HEADING_W-1:0];
	endfunction

	// Offer one request, hold it until accepted, then queue its two poses.
	task automatic send_request(input coord_t cx, input coord_t cy,
			input coord_t tx, input coord_t ty);
		pose_t                 pose;
		logic [HEADING_W-1:0]  heading;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {ty, tx, cy, cx};
		@(posedge clk);
		while (!s_axis_tready) begin
			input_held_cycles++;
			@(posedge clk);
		end
		heading = predict_heading(cx, cy, tx, ty);
		if (cx == tx && cy == ty) begin
			zero_offsets++;
		end
		pose.x       = cx;
		pose.y       = cy;
		pose.heading = heading;
		pose.last    = 1'b0;
		expected_poses.push_back(pose);
		pose.x    = tx;
		pose.y    = ty;
		pose.last = 1'b1;
		expected_poses.push_back(pose);
		requests_sent++;
	endtask

	// Run the sender in bursts; drop valid for a random gap when a burst ends.
	task automatic pace_sender();
		if (burst_left > 0) begin
			burst_left--;
		end
		if (burst_left == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 24);
		end
	endtask

	function automatic coord_t edge_coord();
		case ($urandom_range(0, 5))
			0: return coord_t'(-32768);
			1: return coord_t'(-1);
			2: return coord_t'(0);
			3: return coord_t'(1);
			4: return coord_t'(32767);
			default: return coord_t'($urandom);
		endcase
	endfunction

	task automatic send_paced(input coord_t cx, input coord_t cy,
			input coord_t tx, input coord_t ty);
		send_request(cx, cy, tx, ty);
		pace_sender();
	endtask

	// Axes, quadrant diagonals, zero offset, full span and wrap to zero.
	task automatic test_directed_headings();
		send_paced(0, 0, 100, 0);
		send_paced(0, 0, 0, 100);
		send_paced(0, 0, -100, 0);
		send_paced(0, 0, 0, -100);
		send_paced(10, 10, 20, 20);
		send_paced(10, 10, 0, 20);
		send_paced(10, 10, 0, 0);
		send_paced(10, 10, 20, 0);
		send_paced(0, 0, 0, 0);
		send_paced(32767, -32768, 32767, -32768);
		send_paced(-32768, -32768, -32768, -32768);
		send_paced(-32768, -32768, 32767, 32767);
		send_paced(32767, 32767, -32768, -32768);
		send_paced(-32768, 32767, 32767, -32768);
		send_paced(32767, -32768, -32768, 32767);
		send_paced(-32768, 0, 32767, 0);
		send_paced(0, 32767, 0, -32768);
		// Just below the x axis: rounds up to 2pi and wraps
		send_paced(0, 0, 32767, -1);
		send_paced(-32768, 1, 32767, 0);
		send_paced(-32768, 0, 32767, -1);
		send_paced(0, 1, 32767, 0);
		send_paced(0, 0, -32768, -1);
		send_paced(0, 0, 1, 32767);
	endtask

	// Mostly full-range positions, with short offsets, near-axis and edge values mixed in.
	task automatic test_random_headings();
		coord_t cx;
		coord_t cy;
		coord_t tx;
		coord_t ty;
		int     kind;
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			kind = $urandom_range(0, 9);
			cx = coord_t'($urandom);
			cy = coord_t'($urandom);
			tx = coord_t'($urandom);
			ty = coord_t'($urandom);
			case (kind)
				5, 6: begin
					tx = cx + 16'($urandom_range(0, 16)) - 16'd8;
					ty = cy + 16'($urandom_range(0, 16)) - 16'd8;
				end
				7: begin
					if ($urandom_range(0, 1)) begin
						ty = cy + 16'($urandom_range(0, 4)) - 16'd2;
					end else begin
						tx = cx + 16'($urandom_range(0, 4)) - 16'd2;
					end
				end
				8: begin
					tx = cx;
					ty = cy;
				end
				9: begin
					cx = edge_coord();
					cy = edge_coord();
					tx = edge_coord();
					ty = edge_coord();
				end
				default: begin
				end
			endcase
			send_paced(cx, cy, tx, ty);
		end
	endtask

	// Hold the output off for a long stretch while requests keep coming back to back.
	task automatic test_output_hold_off();
		hold_off_req = 1'b1;
		for (int n = 0; n < HOLD_REQUESTS; n++) begin
			send_request(coord_t'($urandom), coord_t'($urandom),
				coord_t'($urandom), coord_t'($urandom));
		end
	endtask

	// Receiver: switch between stall patterns; serve a hold-off when one is asked.
	initial begin
		rx_mode_t rx_mode;
		int       mode_left;
		rx_mode   = RX_STREAM;
		mode_left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				m_axis_tready <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					rx_mode   = rx_mode_t'($urandom_range(0, 2));
					mode_left = $urandom_range(32, 256);
				end
				mode_left--;
				case (rx_mode)
					RX_STREAM: m_axis_tready <= 1'b1;
					RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
					default:   m_axis_tready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Compare each accepted pose with the oldest one queued.
	always @(posedge clk) begin
		pose_t got;
		pose_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got.x       = m_axis_tdata[COORD_W-1:0];
			got.y       = m_axis_tdata[2*COORD_W-1:COORD_W];
			got.heading = m_axis_tdata[2*COORD_W+HEADING_W-1:2*COORD_W];
			got.last    = m_axis_tlast;
			if (expected_poses.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT) begin
					$display("%0t: unexpected pose x=%0d y=%0d heading=%0d last=%0b",
						$realtime, got.x, got.y, got.heading, got.last);
				end
			end else begin
				want = expected_poses.pop_front();
				poses_checked++;
				if (got !== want) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT) begin
						$display("%0t: pose differs, want x=%0d y=%0d heading=%0d last=%0b",
							$realtime, want.x, want.y, want.heading, want.last);
						$display("%0t:               got  x=%0d y=%0d heading=%0d last=%0b",
							$realtime, got.x, got.y, got.heading, got.last);
					end
				end
			end
		end
	end

	// Watchdog: end the run when neither side moves for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("watchdog: no handshake for %0d cycles, %0d poses still due",
			WATCHDOG_LIMIT, expected_poses.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		burst_left = $urandom_range(1, 24);
		test_directed_headings();
		test_random_headings();
		test_output_hold_off();
		s_axis_tvalid <= 1'b0;
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d requests (%0d with zero offset), %0d poses compared",
			requests_sent, zero_offsets, poses_checked);
		$display("input held off for %0d cycles by output back-pressure", input_held_cycles);
		if (fault_count == 0 && expected_poses.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

`default_nettype wire
